### hdl/utf16_to_utf8_encoder_unit_defines.svh
// assertion macros shared by the encoder modules
// no dependencies; included by files that carry checks
`ifndef UTF16_TO_UTF8_ENCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_UNIT_DEFINES_SVH

// condition holds at every edge outside reset
`define UTE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// same-cycle implication
`define UTE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ute_pkg.sv
// types, constants and byte formatting for the utf-16 to utf-8 encoder
// no dependencies
`default_nettype none

package ute_pkg;

   localparam int unsigned CP_W            = 21;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] HIGH_SURR_TOP  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_TOP   = 16'hDFFF;

   localparam logic [CP_W-1:0] CP_1B_LIMIT = 21'h00080;
   localparam logic [CP_W-1:0] CP_2B_LIMIT = 21'h00800;

   localparam logic [7:0] CONT_MARK = 8'h80;
   localparam logic [7:0] LEAD_2B   = 8'hC0;
   localparam logic [7:0] LEAD_3B   = 8'hE0;
   localparam logic [7:0] LEAD_4B   = 8'hF0;

   typedef enum logic [1:0] {
      LEN_1B = 2'd0,
      LEN_2B = 2'd1,
      LEN_3B = 2'd2,
      LEN_4B = 2'd3
   } len_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_in_run;
      logic       string_end;
      logic       bad_surrogate;
   } rsp_type;

   // one code point waiting to be serialized
   typedef struct packed {
      logic [CP_W-1:0] cp;
      len_type         len;
      logic            err;
      logic            last;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type push_job;
      logic    pop;
   } queue_ctl_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_sts_type;

   function automatic logic [7:0] utf8_byte(job_type j, logic [1:0] idx);
      logic [1:0] rem;
      logic [5:0] payload;
      logic [7:0] b;
      rem     = 2'(j.len) - idx;
      payload = 6'd0;
      b       = 8'd0;
      if (j.err) begin
         b = 8'd0;
      end else if (idx == 2'd0) begin
         case (j.len)
            LEN_1B:  b = {1'b0, j.cp[6:0]};
            LEN_2B:  b = LEAD_2B | {3'b000, j.cp[10:6]};
            LEN_3B:  b = LEAD_3B | {4'b0000, j.cp[15:12]};
            LEN_4B:  b = LEAD_4B | {5'b00000, j.cp[20:18]};
            default: b = 8'd0;
         endcase
      end else begin
         case (rem)
            2'd0:    payload = j.cp[5:0];
            2'd1:    payload = j.cp[11:6];
            default: payload = j.cp[17:12];
         endcase
         b = CONT_MARK | {2'b00, payload};
      end
      return b;
   endfunction

endpackage

`default_nettype wire

### hdl/utf16_to_utf8_encoder_unit.sv
// utf-16 code units in, utf-8 bytes out, one byte per beat
// path: a unit's job is written into the queue, then each of its bytes is registered in the output slot
// throughput: one output byte per cycle while rsp_ready is high; a unit yields 1 to 4 bytes
// (3 for bmp code points from 0x800 up); held high surrogates and units skipped after an error yield none
// a queue of QUEUE_DEPTH jobs lets the front accept while bytes drain
// reset: synchronous active-high, clears surrogate state, queue and output valid
`default_nettype none

module utf16_to_utf8_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = ute_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ute_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ute_pkg::rsp_type rsp_data
);

   ute_pkg::queue_ctl_type q_ctl;
   ute_pkg::queue_sts_type q_sts;
   logic                   accept;
   logic                   push;
   logic                   pop;
   ute_pkg::job_type       job;

   assign req_ready = !q_sts.full;
   assign accept    = req_valid && req_ready;

   ute_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .unit   (req_data),
      .push   (push),
      .job    (job)
   );

   assign q_ctl.push     = push;
   assign q_ctl.push_job = job;
   assign q_ctl.pop      = pop;

   ute_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (q_ctl),
      .sts   (q_sts)
   );

   ute_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sts       (q_sts),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/ute_front.sv
// front end: surrogate pairing, error detection and length classification
// depends on ute_pkg and the assertion macro header
`default_nettype none
`include "utf16_to_utf8_encoder_unit_defines.svh"

module ute_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire ute_pkg::req_type unit,
   output      logic             push,
   output      ute_pkg::job_type job
);

   logic       pending_ff, pending_in;
   logic [9:0] high_ff, high_in;
   logic       skip_ff, skip_in;
   logic [10:0] plane;

   always_comb begin
      pending_in = pending_ff;
      high_in    = high_ff;
      skip_in    = skip_ff;
      push       = 1'b0;
      // 0x10000 is 64 << 10, so the offset lands on the upper bits
      plane      = {1'b0, high_ff} + 11'd64;
      job.cp     = '0;
      job.len    = ute_pkg::LEN_1B;
      job.err    = 1'b0;
      job.last   = unit.last_unit;

      if (accept) begin
         if (skip_ff) begin
            if (unit.last_unit) begin
               skip_in = 1'b0;
            end
         end else if (pending_ff) begin
            if (unit.code_unit inside
                {[ute_pkg::LOW_SURR_BASE:ute_pkg::LOW_SURR_TOP]}) begin
               // (high - d800) << 10 | (low - dc00), plus 0x10000
               job.cp     = {plane, unit.code_unit[9:0]};
               job.len    = ute_pkg::LEN_4B;
               push       = 1'b1;
               pending_in = 1'b0;
               high_in    = '0;
            end else begin
               push       = 1'b1;
               job.err    = 1'b1;
               job.last   = 1'b1;
               pending_in = 1'b0;
               high_in    = '0;
               skip_in    = !unit.last_unit;
            end
         end else if (unit.code_unit inside
                      {[ute_pkg::HIGH_SURR_BASE:ute_pkg::LOW_SURR_TOP]}) begin
            if (unit.code_unit >= ute_pkg::LOW_SURR_BASE || unit.last_unit) begin
               push    = 1'b1;
               job.err = 1'b1;
               job.last = 1'b1;
               skip_in = !unit.last_unit;
            end else begin
               pending_in = 1'b1;
               high_in    = unit.code_unit[9:0];
            end
         end else begin
            job.cp = {5'b00000, unit.code_unit};
            push   = 1'b1;
            if (job.cp < ute_pkg::CP_1B_LIMIT) begin
               job.len = ute_pkg::LEN_1B;
            end else if (job.cp < ute_pkg::CP_2B_LIMIT) begin
               job.len = ute_pkg::LEN_2B;
            end else begin
               job.len = ute_pkg::LEN_3B;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         high_ff    <= '0;
         skip_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         high_ff    <= high_in;
         skip_ff    <= skip_in;
      end
   end

   `UTE_ASSERT_ALWAYS(a_pending_not_skipping, clock, reset, !(pending_ff && skip_ff), "high surrogate held while dropping")
   `UTE_ASSERT_IMPLY(a_err_ends_string, clock, reset, push && job.err, job.last && !pending_in, "error job must close the string")

endmodule

`default_nettype wire

### hdl/ute_queue.sv
// short job queue between the front end and the byte serializer
// depends on ute_pkg and the assertion macro header
`default_nettype none
`include "utf16_to_utf8_encoder_unit_defines.svh"

module ute_queue #(
   parameter int unsigned DEPTH = ute_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ute_pkg::queue_ctl_type ctl,
   output      ute_pkg::queue_sts_type sts
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   ute_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({ctl.push, ctl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= ctl.push_job;
      end
   end

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == DEPTH_CNT);
   assign sts.head  = mem_ff[rd_ptr_ff];

   `UTE_ASSERT_IMPLY(a_no_pop_empty, clock, reset, ctl.pop, count_ff != '0, "pop from empty queue")
   `UTE_ASSERT_IMPLY(a_no_push_full, clock, reset, ctl.push && !ctl.pop, count_ff != DEPTH_CNT, "push into full queue")
   `UTE_ASSERT_NEXT(a_count_tracks, clock, reset, ctl.push && !ctl.pop, count_ff == $past(count_ff) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

### hdl/ute_back.sv
// back end: serializes queued code points into utf-8 bytes, one per cycle while rsp_ready is high
// depends on ute_pkg and the assertion macro header
`default_nettype none
`include "utf16_to_utf8_encoder_unit_defines.svh"

module ute_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ute_pkg::queue_sts_type sts,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      ute_pkg::rsp_type       rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   ute_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load;
   logic             final_beat;

   always_comb begin
      // output slot free or being drained this cycle
      load         = !rsp_valid_ff || rsp_ready;
      final_beat   = (idx_ff == 2'(sts.head.len));
      pop          = load && !sts.empty && final_beat;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = !sts.empty;
         rsp_data_in.out_byte      = ute_pkg::utf8_byte(sts.head, idx_ff);
         rsp_data_in.last_in_run   = final_beat;
         rsp_data_in.string_end    = final_beat && sts.head.last;
         rsp_data_in.bad_surrogate = sts.head.err;
         if (!sts.empty) begin
            idx_in = final_beat ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `UTE_ASSERT_IMPLY(a_err_beat_shape, clock, reset, rsp_valid_ff && rsp_data_ff.bad_surrogate, rsp_data_ff.out_byte == 8'd0 && rsp_data_ff.last_in_run && rsp_data_ff.string_end, "malformed error beat")

endmodule

`default_nettype wire
